// File: hw/rtl/fta_pkg.sv
// Shared constants for the fixed-timestep accumulator.
// Field widths, register indexes, reset values and serial unit sizing.
// No dependencies.
package fta_pkg;

    localparam int TIME_W             = 64;
    localparam int DELTA_W            = 32;
    localparam int ACC_W              = 33;
    localparam int TOTAL_W            = 48;
    localparam int TICKS_W            = 8;
    localparam int DIGIT_W            = 4;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 32;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS   = 2'd2;

    localparam logic [DELTA_W-1:0] PERIOD_RESET    = 32'd16666666;
    localparam logic [DELTA_W-1:0] MAX_FRAME_RESET = 32'd250000000;
    localparam logic [TICKS_W-1:0] MAX_TICKS_RESET = 8'd5;
    localparam logic [TICKS_W-1:0] MAX_TICKS_FLOOR = 8'd1;

endpackage

// File: hw/rtl/fta_if.sv
// Handshake channels of the fixed-timestep accumulator: input, result, configuration.
// Depends on fta_pkg for field widths.
interface fta_in_if;
    logic                       valid;
    logic                       ready;
    logic [fta_pkg::TIME_W-1:0] now_time_ns;

    modport source (output valid, output now_time_ns, input ready);
    modport sink (input valid, input now_time_ns, output ready);
endinterface

interface fta_out_if #(
    parameter int FRACTION_BITS = fta_pkg::FRACTION_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [fta_pkg::TICKS_W-1:0] ticks_due;
    logic [fta_pkg::DELTA_W-1:0] frame_delta_ns;
    logic [FRACTION_BITS:0]      blend_fraction;
    logic [fta_pkg::TOTAL_W-1:0] total_ticks;

    modport source (output valid, output ticks_due, output frame_delta_ns,
                    output blend_fraction, output total_ticks, input ready);
    modport sink (input valid, input ticks_due, input frame_delta_ns,
                  input blend_fraction, input total_ticks, output ready);
endinterface

interface fta_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fta_pkg::CFG_IDX_W-1:0]  index;
    logic [fta_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/fta_delta.sv
// Digit-serial 64-bit subtractor: now minus last time, one 4-bit digit per cycle.
// Depends on fta_pkg.
module fta_delta (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fta_pkg::TIME_W-1:0] now_time,
    input  logic [fta_pkg::TIME_W-1:0] last_time,
    output logic                       done,
    output logic [fta_pkg::TIME_W-1:0] raw_delta,
    output logic                       backward
);

    localparam int NUM_DIGITS = fta_pkg::TIME_W / fta_pkg::DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);

    logic [fta_pkg::TIME_W-1:0]  a_reg, a_next;
    logic [fta_pkg::TIME_W-1:0]  b_reg, b_next;
    logic [fta_pkg::TIME_W-1:0]  diff_reg, diff_next;
    logic                        borrow_reg, borrow_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [fta_pkg::DIGIT_W:0]   digit_sum;

    always_comb
    begin
        digit_sum = {1'b0, a_reg[fta_pkg::DIGIT_W-1:0]}
                  - {1'b0, b_reg[fta_pkg::DIGIT_W-1:0]}
                  - {{fta_pkg::DIGIT_W{1'b0}}, borrow_reg};
        a_next      = a_reg;
        b_next      = b_reg;
        diff_next   = diff_reg;
        borrow_next = borrow_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            a_next      = now_time;
            b_next      = last_time;
            borrow_next = 1'b0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next      = a_reg >> fta_pkg::DIGIT_W;
            b_next      = b_reg >> fta_pkg::DIGIT_W;
            diff_next   = {digit_sum[fta_pkg::DIGIT_W-1:0],
                           diff_reg[fta_pkg::TIME_W-1:fta_pkg::DIGIT_W]};
            borrow_next = digit_sum[fta_pkg::DIGIT_W];
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            borrow_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            borrow_reg <= borrow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        diff_reg <= diff_next;
    end

    assign done      = done_reg;
    assign raw_delta = diff_reg;
    assign backward  = borrow_reg;

endmodule

// File: hw/rtl/fta_div.sv
// Bit-serial restoring divider: accumulator by period, then fraction bits.
// Gives the whole quotient, fraction bits and the remainder after the integer part.
// Depends on fta_pkg.
module fta_div #(
    parameter int FRACTION_BITS = fta_pkg::FRACTION_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [fta_pkg::ACC_W-1:0]                dividend,
    input  logic [fta_pkg::DELTA_W-1:0]              divisor,
    output logic                                     done,
    output logic [fta_pkg::ACC_W+FRACTION_BITS-1:0]  quotient,
    output logic [fta_pkg::DELTA_W-1:0]              remainder
);

    localparam int STEPS = fta_pkg::ACC_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [STEPS-1:0]              num_reg, num_next;
    logic [STEPS-1:0]              quo_reg, quo_next;
    logic [fta_pkg::DELTA_W-1:0]   rem_reg, rem_next;
    logic [fta_pkg::DELTA_W-1:0]   mod_reg, mod_next;
    logic [fta_pkg::DELTA_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [fta_pkg::DELTA_W:0]     trial;
    logic [fta_pkg::DELTA_W:0]     trial_sub;
    logic                          fits;
    logic [fta_pkg::DELTA_W-1:0]   rem_step;

    always_comb
    begin
        trial     = {rem_reg, num_reg[STEPS-1]};
        trial_sub = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
        rem_step  = fits ? trial_sub[fta_pkg::DELTA_W-1:0] : trial[fta_pkg::DELTA_W-1:0];
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = {dividend, {FRACTION_BITS{1'b0}}};
            quo_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            quo_next = {quo_reg[STEPS-2:0], fits};
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fta_pkg::ACC_W - 1))
            begin
                mod_next = rem_step;
            end
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = mod_reg;

endmodule

// File: hw/rtl/fixed_timestep_accumulator_core.sv
// An accepted word passes through the 4-bit serial subtractor, the divider and the output
// register in fixed mode; the first word after reset skips the subtractor, variable mode
// (tick period zero) skips the divider, and a first word in variable mode skips both.
// One word in flight: the next word is taken while a result waits in the output register,
// and a second result stalls the input.
// Reset restores the register defaults and clears the start flag, accumulator and tick total.
module fixed_timestep_accumulator_core #(
    parameter int FRACTION_BITS = fta_pkg::FRACTION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fta_in_if.sink    in_ch,
    fta_out_if.source out_ch,
    fta_cfg_if.sink   cfg_ch
);

    localparam int QUO_W = fta_pkg::ACC_W + FRACTION_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [fta_pkg::DELTA_W-1:0]   period_reg;
    logic [fta_pkg::DELTA_W-1:0]   max_frame_reg;
    logic [fta_pkg::TICKS_W-1:0]   max_ticks_reg;
    logic                          started_reg, started_next;
    logic [fta_pkg::TIME_W-1:0]    last_time_reg, last_time_next;
    logic [fta_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [fta_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [fta_pkg::DELTA_W-1:0]   delta_reg, delta_next;
    logic [fta_pkg::TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [FRACTION_BITS:0]        frac_reg, frac_next;
    logic                          out_valid_reg, out_valid_next;
    logic [fta_pkg::TICKS_W-1:0]   out_ticks_reg, out_ticks_next;
    logic [fta_pkg::DELTA_W-1:0]   out_delta_reg, out_delta_next;
    logic [FRACTION_BITS:0]        out_frac_reg, out_frac_next;
    logic [fta_pkg::TOTAL_W-1:0]   out_total_reg, out_total_next;

    logic                          in_fire;
    logic                          dlt_start, dlt_done, dlt_backward;
    logic [fta_pkg::TIME_W-1:0]    dlt_raw;
    logic                          div_start, div_done;
    logic [fta_pkg::ACC_W-1:0]     div_dividend;
    logic [QUO_W-1:0]              div_quotient;
    logic [fta_pkg::DELTA_W-1:0]   div_remainder;
    logic [fta_pkg::DELTA_W-1:0]   frame_cap;
    logic [fta_pkg::TICKS_W-1:0]   tick_cap;
    logic [fta_pkg::ACC_W-1:0]     whole;
    logic                          raw_below_cap;

    fta_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dlt_start),
        .now_time  (in_ch.now_time_ns),
        .last_time (last_time_reg),
        .done      (dlt_done),
        .raw_delta (dlt_raw),
        .backward  (dlt_backward)
    );

    fta_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (period_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign frame_cap     = (max_frame_reg == '0) ? fta_pkg::MAX_FRAME_RESET : max_frame_reg;
    assign tick_cap      = (max_ticks_reg == '0) ? fta_pkg::MAX_TICKS_FLOOR : max_ticks_reg;
    assign raw_below_cap = (dlt_raw[fta_pkg::TIME_W-1:fta_pkg::DELTA_W] == '0)
                        && (dlt_raw[fta_pkg::DELTA_W-1:0] < frame_cap);
    assign div_dividend  = acc_reg + {1'b0, delta_reg};
    assign whole         = div_quotient[QUO_W-1:FRACTION_BITS];

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        last_time_next = last_time_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        delta_next     = delta_reg;
        ticks_next     = ticks_reg;
        frac_next      = frac_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_ticks_next = out_ticks_reg;
        out_delta_next = out_delta_reg;
        out_frac_next  = out_frac_reg;
        out_total_next = out_total_reg;
        dlt_start      = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_time_next = in_ch.now_time_ns;
                    started_next   = 1'b1;
                    if (started_reg)
                    begin
                        dlt_start  = 1'b1;
                        state_next = S_DELTA;
                    end
                    else
                    begin
                        delta_next = '0;
                        state_next = S_ACC;
                    end
                end
            end
            S_DELTA:
            begin
                if (dlt_done)
                begin
                    if (dlt_backward)
                    begin
                        delta_next = '0;
                    end
                    else if (raw_below_cap)
                    begin
                        delta_next = dlt_raw[fta_pkg::DELTA_W-1:0];
                    end
                    else
                    begin
                        delta_next = frame_cap;
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (period_reg == '0)
                begin
                    ticks_next = fta_pkg::TICKS_W'(1);
                    frac_next  = {1'b1, {FRACTION_BITS{1'b0}}};
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (whole < {{(fta_pkg::ACC_W - fta_pkg::TICKS_W){1'b0}}, tick_cap})
                    begin
                        ticks_next = whole[fta_pkg::TICKS_W-1:0];
                    end
                    else
                    begin
                        ticks_next = tick_cap;
                    end
                    acc_next   = {1'b0, div_remainder};
                    frac_next  = {1'b0, div_quotient[FRACTION_BITS-1:0]};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    total_next     = total_reg
                                   + {{(fta_pkg::TOTAL_W - fta_pkg::TICKS_W){1'b0}}, ticks_reg};
                    out_valid_next = 1'b1;
                    out_ticks_next = ticks_reg;
                    out_delta_next = delta_reg;
                    out_frac_next  = frac_reg;
                    out_total_next = total_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= fta_pkg::PERIOD_RESET;
            max_frame_reg <= fta_pkg::MAX_FRAME_RESET;
            max_ticks_reg <= fta_pkg::MAX_TICKS_RESET;
            started_reg   <= 1'b0;
            last_time_reg <= '0;
            acc_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            last_time_reg <= last_time_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    fta_pkg::REG_TICK_PERIOD: period_reg    <= cfg_ch.data;
                    fta_pkg::REG_MAX_FRAME:   max_frame_reg <= cfg_ch.data;
                    fta_pkg::REG_MAX_TICKS:
                        max_ticks_reg <= cfg_ch.data[fta_pkg::TICKS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        ticks_reg     <= ticks_next;
        frac_reg      <= frac_next;
        out_ticks_reg <= out_ticks_next;
        out_delta_reg <= out_delta_next;
        out_frac_reg  <= out_frac_next;
        out_total_reg <= out_total_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.ticks_due      = out_ticks_reg;
    assign out_ch.frame_delta_ns = out_delta_reg;
    assign out_ch.blend_fraction = out_frac_reg;
    assign out_ch.total_ticks    = out_total_reg;

endmodule

// File: hw/rtl/fta_checker.sv
// Port-level checks for the fixed-timestep accumulator core, attached with bind.
// Depends on fta_pkg and on the ports of fixed_timestep_accumulator_core.
module fta_checker #(
    parameter int FRACTION_BITS = fta_pkg::FRACTION_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [fta_pkg::TICKS_W-1:0] ticks_due,
    input logic [FRACTION_BITS:0]      blend_fraction,
    input logic [fta_pkg::TOTAL_W-1:0] total_ticks
);

    logic [fta_pkg::TOTAL_W-1:0] last_total_reg;
    logic                        has_prev_reg;
    logic [fta_pkg::TOTAL_W-1:0] expected_total;

    assign expected_total = last_total_reg
                          + {{(fta_pkg::TOTAL_W - fta_pkg::TICKS_W){1'b0}}, ticks_due};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_prev_reg   <= 1'b0;
            last_total_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            has_prev_reg   <= 1'b1;
            last_total_reg <= total_ticks;
        end
    end

    // A stalled result word keeps its running total and fraction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_ticks)
                                    && $stable(blend_fraction))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blend_fraction <= {1'b1, {FRACTION_BITS{1'b0}}})
        else $error("blend fraction above one");

    // Only one word is processed at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_prev_reg |-> total_ticks == expected_total)
        else $error("tick total does not follow granted ticks");

endmodule

bind fixed_timestep_accumulator_core fta_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_fta_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .ticks_due      (out_ch.ticks_due),
    .blend_fraction (out_ch.blend_fraction),
    .total_ticks    (out_ch.total_ticks)
);
